### design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### design/pcmu3_pkg.sv
// Package with types and constants of the stereo upsample-by-three block.
`timescale 1ns / 1ps

package pcmu3_pkg;

  // Input item kind
  typedef enum logic {
    KIND_SAMPLE  = 1'b0,
    KIND_RESTART = 1'b1
  } kind_t;

  // Frame index within one sample
  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] sample;
    logic               end_of_block;
  } in_t;

  typedef struct packed {
    logic signed [31:0] left_word;
    logic signed [31:0] right_word;
    logic               last_of_sample;
    logic               block_end;
  } out_t;

  // Work handed from front to back: one entry per audio sample
  typedef struct packed {
    logic signed [15:0] prev;
    logic signed [15:0] cur;
    logic               primed;
    logic               eob;
  } job_t;

  localparam int JOB_W = $bits(job_t);
  localparam int OUT_W = $bits(out_t);

  localparam int JOB_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 4;

  // ceil(2^17 / 3): exact floor(m / 3) for all m below 2^17
  localparam logic [16:0] RECIP3 = 17'd43691;
  localparam int RECIP3_SHIFT = 17;

endpackage

### design/pcmu3_fifo.sv
// Small register queue with occupancy count.
`timescale 1ns / 1ps

module pcmu3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(DEPTH));
  assign count   = cnt_r;
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers with wrap, track occupancy
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

### design/pcmu3_front.sv
// Front end: accepts items, handles restart, keeps the previous sample.
`timescale 1ns / 1ps

module pcmu3_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  pcmu3_pkg::in_t   in_data,
  output logic             in_full,
  input  logic             job_full,
  output logic             job_push,
  output pcmu3_pkg::job_t  job_data
);

  logic signed [15:0] prev_r, prev_nxt;
  logic               primed_r, primed_nxt;
  logic               accept;
  logic               is_restart;

  assign in_full    = job_full;
  assign accept     = in_push && !job_full;
  assign is_restart = (in_data.kind == pcmu3_pkg::KIND_RESTART);

  // Hand every audio sample to the back end with the interpolator state
  assign job_push        = accept && !is_restart;
  assign job_data.prev   = prev_r;
  assign job_data.cur    = in_data.sample;
  assign job_data.primed = primed_r;
  assign job_data.eob    = in_data.end_of_block;

  // Restart clears state; a sample becomes the next previous sample
  always_comb begin
    prev_nxt   = prev_r;
    primed_nxt = primed_r;
    if (accept) begin
      if (is_restart) begin
        prev_nxt   = '0;
        primed_nxt = 1'b0;
      end else begin
        prev_nxt   = in_data.sample;
        primed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      primed_r <= 1'b0;
    end else begin
      prev_r   <= prev_nxt;
      primed_r <= primed_nxt;
    end
  end

endmodule

### design/pcmu3_back.sv
// Back end: expands one job into three frames through a two-step divide by three.
`timescale 1ns / 1ps

module pcmu3_back #(
  parameter int OUT_DEPTH = pcmu3_pkg::OUT_DEPTH_DEF,
  localparam int CW = $clog2(OUT_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pcmu3_pkg::job_t  job_data,
  input  logic             job_empty,
  output logic             job_pop,
  input  logic [CW-1:0]    out_count,
  output logic             out_push,
  output pcmu3_pkg::out_t  out_data
);

  pcmu3_pkg::phase_t  phase_r, phase_nxt;
  logic signed [15:0] base;
  logic signed [17:0] pe, ce, num;
  logic [17:0]        num_neg;
  logic [CW:0]        occ;
  logic               issue;
  logic               is_last;

  logic               vld_r, vld_nxt;
  logic               sign_r;
  logic [16:0]        mag_r;
  logic               last_r, blk_r;

  logic [33:0]        prod;
  logic [15:0]        quo, quo_neg, res;

  // Issue a frame while the output queue has room for everything in flight
  assign occ     = {1'b0, out_count} + (CW + 1)'(vld_r);
  assign issue   = !job_empty && (occ < (CW + 1)'(OUT_DEPTH));
  assign is_last = (phase_r == pcmu3_pkg::PH_2);
  assign job_pop = issue && is_last;

  // Unprimed: treat the sample as its own predecessor, all frames equal it
  assign base = job_data.primed ? job_data.prev : job_data.cur;
  assign pe   = 18'(base);
  assign ce   = 18'(job_data.cur);

  // Numerator (3-w)*prev + w*cur, magnitude always below 2^17
  always_comb begin
    case (phase_r)
      pcmu3_pkg::PH_0: num = (pe <<< 1) + pe;
      pcmu3_pkg::PH_1: num = (pe <<< 1) + ce;
      pcmu3_pkg::PH_2: num = pe + (ce <<< 1);
      default:         num = (pe <<< 1) + pe;
    endcase
  end

  assign num_neg = -num;

  // Advance frame index
  always_comb begin
    phase_nxt = phase_r;
    if (issue) begin
      unique case (phase_r)
        pcmu3_pkg::PH_0: phase_nxt = pcmu3_pkg::PH_1;
        pcmu3_pkg::PH_1: phase_nxt = pcmu3_pkg::PH_2;
        pcmu3_pkg::PH_2: phase_nxt = pcmu3_pkg::PH_0;
        default:         phase_nxt = pcmu3_pkg::PH_0;
      endcase
    end
  end

  assign vld_nxt = issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pcmu3_pkg::PH_0;
      vld_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      vld_r   <= vld_nxt;
    end
  end

  // Stage one: sign and magnitude of the numerator, frame flags
  always_ff @(posedge clk) begin
    if (issue) begin
      sign_r <= num[17];
      mag_r  <= num[17] ? num_neg[16:0] : num[16:0];
      last_r <= is_last;
      blk_r  <= is_last && job_data.eob;
    end
  end

  // Stage two: reciprocal multiply, restore sign, scale to Q31
  assign prod    = 34'(mag_r) * 34'(pcmu3_pkg::RECIP3);
  assign quo     = prod[pcmu3_pkg::RECIP3_SHIFT +: 16];
  assign quo_neg = ~quo + 16'd1;
  assign res     = sign_r ? quo_neg : quo;

  assign out_push                = vld_r;
  assign out_data.left_word      = {res, 16'h0000};
  assign out_data.right_word     = {res, 16'h0000};
  assign out_data.last_of_sample = last_r;
  assign out_data.block_end      = blk_r;

endmodule

### design/pcm_upsample_by_three_stereo_top.sv
// Top level of the mono PCM to stereo Q31 upsampler by three.
//
// Usage:
//   Input queue side: drive in_data and raise in_push; the transaction is taken
//   at a rising edge with in_push high and in_full low. kind selects an audio
//   sample or a restart of the interpolator (restart gives no frames).
//   Output queue side: while out_empty is low, out_data holds the oldest frame;
//   raise out_pop to take it. Each sample gives three frames in order.
//   A sample goes through the job queue, the back end's stage-one registers
//   and the output queue. Throughput: one frame per cycle while a job waits and
//   the output queue has room, set by the back end's single divide-by-three path.
//   A job queue of JOB_DEPTH samples lets input run ahead of the back end; an
//   output queue of OUT_DEPTH frames absorbs pop stalls. When out_pop stays low
//   the output queue fills, the back end halts, then the job queue fills and
//   in_full rises; nothing is dropped.
//   Reset (rst_n low, synchronous) empties both queues and clears the previous
//   sample and the primed flag, so the next sample is repeated three times.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcm_upsample_by_three_stereo_top #(
  parameter int JOB_DEPTH = pcmu3_pkg::JOB_DEPTH_DEF,
  parameter int OUT_DEPTH = pcmu3_pkg::OUT_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  input  pcmu3_pkg::in_t  in_data,
  output logic            in_full,
  output logic            out_empty,
  input  logic            out_pop,
  output pcmu3_pkg::out_t out_data
);

  localparam int JCW = $clog2(JOB_DEPTH + 1);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  logic                         job_push, job_pop, job_empty, job_full;
  pcmu3_pkg::job_t              job_wdata, job_rdata;
  logic [pcmu3_pkg::JOB_W-1:0]  job_rbits;
  logic [JCW-1:0]               job_count;

  logic                         ofifo_push, ofifo_full;
  pcmu3_pkg::out_t              ofifo_wdata;
  logic [pcmu3_pkg::OUT_W-1:0]  ofifo_rbits;
  logic [OCW-1:0]               ofifo_count;

  // Accept and classify
  pcmu3_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .job_full (job_full),
    .job_push (job_push),
    .job_data (job_wdata)
  );

  // Queue samples between front and back
  pcmu3_fifo #(
    .WIDTH (pcmu3_pkg::JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_wdata),
    .pop   (job_pop),
    .rdata (job_rbits),
    .empty (job_empty),
    .full  (job_full),
    .count (job_count)
  );

  assign job_rdata = job_rbits;

  // Expand each sample into three frames
  pcmu3_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_data  (job_rdata),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .out_count (ofifo_count),
    .out_push  (ofifo_push),
    .out_data  (ofifo_wdata)
  );

  // Hold frames for the receiver
  pcmu3_fifo #(
    .WIDTH (pcmu3_pkg::OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ofifo_push),
    .wdata (ofifo_wdata),
    .pop   (out_pop),
    .rdata (ofifo_rbits),
    .empty (out_empty),
    .full  (ofifo_full),
    .count (ofifo_count)
  );

  assign out_data = ofifo_rbits;

  // Checks
  `ASSERT_SAME(a_no_out_overflow, ofifo_push, !ofifo_full, "frame pushed into full output queue")
  `ASSERT_SAME(a_restart_no_job, in_push && !in_full && in_data.kind == pcmu3_pkg::KIND_RESTART, !job_push, "restart created a job")
  `ASSERT_NEXT(a_sample_queued, in_push && !in_full && in_data.kind == pcmu3_pkg::KIND_SAMPLE, !job_empty && job_count != '0, "accepted sample missing from job queue")

endmodule
